// ----- hdl/ilr_pkg.sv -----
// Shared widths, codes and the command word type of the line rasterizer.
`default_nettype none
package ilr_pkg;

    localparam int COORD_BITS  = 12;
    localparam int ERR_BITS    = COORD_BITS + 3;
    localparam int LEFT_BITS   = COORD_BITS + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [COORD_BITS-1:0]        delta_t;
    typedef logic signed [ERR_BITS-1:0]   err_t;
    typedef logic [LEFT_BITS-1:0]         left_t;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_STEP = 1'b1
    } kind_t;

    // Classified command word passed from the front end to the back end.
    typedef struct packed {
        kind_t  kind;
        coord_t start_x;
        coord_t start_y;
        delta_t major;
        delta_t minor;
        logic   x_neg;
        logic   y_neg;
        logic   swapped;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } queue_wr_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } queue_rd_t;

endpackage : ilr_pkg
`default_nettype wire

// ----- hdl/ilr_if.sv -----
// Valid/ready channel interfaces for command words and pixel words.
`default_nettype none
interface ilr_cmd_if;
    logic           valid;
    logic           ready;
    logic           kind;
    ilr_pkg::coord_t start_x;
    ilr_pkg::coord_t start_y;
    ilr_pkg::coord_t end_x;
    ilr_pkg::coord_t end_y;

    modport source (output valid, kind, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, kind, start_x, start_y, end_x, end_y, output ready);
endinterface : ilr_cmd_if

interface ilr_pixel_if;
    logic            valid;
    logic            ready;
    ilr_pkg::coord_t pixel_x;
    ilr_pkg::coord_t pixel_y;
    logic            last;

    modport source (output valid, pixel_x, pixel_y, last, input ready);
    modport sink   (input valid, pixel_x, pixel_y, last, output ready);
endinterface : ilr_pixel_if
`default_nettype wire

// ----- hdl/ilr_front.sv -----
// Front end: accept command words and classify line loads into octant data.
`default_nettype none
module ilr_front (
    ilr_cmd_if.sink             cmd,
    input  wire logic           queue_full,
    output ilr_pkg::queue_wr_t  queue_wr
);

    logic signed [ilr_pkg::COORD_BITS:0] diff_x;
    logic signed [ilr_pkg::COORD_BITS:0] diff_y;
    logic signed [ilr_pkg::COORD_BITS:0] mag_x;
    logic signed [ilr_pkg::COORD_BITS:0] mag_y;
    ilr_pkg::delta_t                     dx;
    ilr_pkg::delta_t                     dy;
    logic                                steep;

    assign cmd.ready = !queue_full;

    always_comb
    begin
        diff_x = {cmd.end_x[ilr_pkg::COORD_BITS-1], cmd.end_x}
               - {cmd.start_x[ilr_pkg::COORD_BITS-1], cmd.start_x};
        diff_y = {cmd.end_y[ilr_pkg::COORD_BITS-1], cmd.end_y}
               - {cmd.start_y[ilr_pkg::COORD_BITS-1], cmd.start_y};
        mag_x  = diff_x[ilr_pkg::COORD_BITS] ? -diff_x : diff_x;
        mag_y  = diff_y[ilr_pkg::COORD_BITS] ? -diff_y : diff_y;
        dx     = mag_x[ilr_pkg::COORD_BITS-1:0];
        dy     = mag_y[ilr_pkg::COORD_BITS-1:0];
        steep  = dx < dy;

        queue_wr.valid       = cmd.valid && !queue_full;
        queue_wr.cmd.kind    = ilr_pkg::kind_t'(cmd.kind);
        queue_wr.cmd.start_x = cmd.start_x;
        queue_wr.cmd.start_y = cmd.start_y;
        queue_wr.cmd.major   = steep ? dy : dx;
        queue_wr.cmd.minor   = steep ? dx : dy;
        // A zero delta counts as a negative step, as does a decreasing axis.
        queue_wr.cmd.x_neg   = diff_x[ilr_pkg::COORD_BITS] || (diff_x == '0);
        queue_wr.cmd.y_neg   = diff_y[ilr_pkg::COORD_BITS] || (diff_y == '0);
        queue_wr.cmd.swapped = steep;
    end

endmodule : ilr_front
`default_nettype wire

// ----- hdl/ilr_queue.sv -----
// Short command queue between the front end and the back end.
`default_nettype none
module ilr_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ilr_pkg::queue_wr_t  queue_wr,
    input  wire logic                pop,
    output logic                     full,
    output ilr_pkg::queue_rd_t       queue_rd
);

    ilr_pkg::cmd_t                     entry_reg [ilr_pkg::QUEUE_DEPTH];
    logic [ilr_pkg::QPTR_BITS-1:0]     wr_ptr_reg;
    logic [ilr_pkg::QPTR_BITS-1:0]     rd_ptr_reg;
    logic [ilr_pkg::QCNT_BITS-1:0]     count_reg;
    logic [ilr_pkg::QCNT_BITS-1:0]     count_next;
    logic                              do_pop;

    assign full           = count_reg == ilr_pkg::QCNT_BITS'(ilr_pkg::QUEUE_DEPTH);
    assign queue_rd.valid = count_reg != '0;
    assign queue_rd.cmd   = entry_reg[rd_ptr_reg];
    assign do_pop         = pop && queue_rd.valid;

    always_comb
    begin
        count_next = count_reg;
        if (queue_wr.valid && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!queue_wr.valid && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (queue_wr.valid)
            begin
                wr_ptr_reg <= (wr_ptr_reg == ilr_pkg::QPTR_BITS'(ilr_pkg::QUEUE_DEPTH - 1))
                            ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == ilr_pkg::QPTR_BITS'(ilr_pkg::QUEUE_DEPTH - 1))
                            ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (queue_wr.valid)
        begin
            entry_reg[wr_ptr_reg] <= queue_wr.cmd;
        end
    end

endmodule : ilr_queue
`default_nettype wire

// ----- hdl/ilr_back.sv -----
// Back end: line state, one Bresenham step per word, registered pixel output.
`default_nettype none
module ilr_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ilr_pkg::queue_rd_t  queue_rd,
    output logic                     pop,
    ilr_pixel_if.source              pixel
);

    ilr_pkg::coord_t cur_x_reg, cur_x_next;
    ilr_pkg::coord_t cur_y_reg, cur_y_next;
    ilr_pkg::err_t   error_reg, error_next;
    ilr_pkg::delta_t major_reg, major_next;
    ilr_pkg::delta_t minor_reg, minor_next;
    ilr_pkg::left_t  left_reg, left_next;
    logic            x_neg_reg, x_neg_next;
    logic            y_neg_reg, y_neg_next;
    logic            swapped_reg, swapped_next;
    logic            active_reg, active_next;
    logic            out_valid_reg, out_valid_next;
    ilr_pkg::coord_t out_x_reg;
    ilr_pkg::coord_t out_y_reg;
    logic            out_last_reg;

    logic            emit;
    logic            is_last;
    ilr_pkg::coord_t step_x;
    ilr_pkg::coord_t step_y;
    ilr_pkg::err_t   two_major;
    ilr_pkg::err_t   two_minor;

    assign pixel.valid   = out_valid_reg;
    assign pixel.pixel_x = out_x_reg;
    assign pixel.pixel_y = out_y_reg;
    assign pixel.last    = out_last_reg;

    // Take a word whenever the output register is free or being drained.
    assign pop     = queue_rd.valid && (!out_valid_reg || pixel.ready);
    assign emit    = pop && (queue_rd.cmd.kind == ilr_pkg::KIND_STEP) && active_reg;
    assign is_last = left_reg <= ilr_pkg::LEFT_BITS'(1);

    always_comb
    begin
        step_x    = x_neg_reg ? '1 : ilr_pkg::COORD_BITS'(1);
        step_y    = y_neg_reg ? '1 : ilr_pkg::COORD_BITS'(1);
        two_major = ilr_pkg::err_t'({major_reg, 1'b0});
        two_minor = ilr_pkg::err_t'({minor_reg, 1'b0});

        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        error_next   = error_reg;
        major_next   = major_reg;
        minor_next   = minor_reg;
        left_next    = left_reg;
        x_neg_next   = x_neg_reg;
        y_neg_next   = y_neg_reg;
        swapped_next = swapped_reg;
        active_next  = active_reg;

        if (pop && (queue_rd.cmd.kind == ilr_pkg::KIND_LOAD))
        begin
            cur_x_next   = queue_rd.cmd.start_x;
            cur_y_next   = queue_rd.cmd.start_y;
            major_next   = queue_rd.cmd.major;
            minor_next   = queue_rd.cmd.minor;
            x_neg_next   = queue_rd.cmd.x_neg;
            y_neg_next   = queue_rd.cmd.y_neg;
            swapped_next = queue_rd.cmd.swapped;
            error_next   = ilr_pkg::err_t'({queue_rd.cmd.minor, 1'b0})
                         - ilr_pkg::err_t'(queue_rd.cmd.major);
            left_next    = ilr_pkg::left_t'(queue_rd.cmd.major) + 1'b1;
            active_next  = 1'b1;
        end
        else if (emit)
        begin
            if (is_last)
            begin
                left_next   = '0;
                active_next = 1'b0;
            end
            else
            begin
                // Advance the major axis always, the minor one on a non-negative error.
                if (swapped_reg)
                begin
                    cur_y_next = cur_y_reg + step_y;
                    if (!error_reg[ilr_pkg::ERR_BITS-1])
                    begin
                        cur_x_next = cur_x_reg + step_x;
                    end
                end
                else
                begin
                    cur_x_next = cur_x_reg + step_x;
                    if (!error_reg[ilr_pkg::ERR_BITS-1])
                    begin
                        cur_y_next = cur_y_reg + step_y;
                    end
                end
                error_next = error_reg + two_minor
                           - (error_reg[ilr_pkg::ERR_BITS-1] ? '0 : two_major);
                left_next  = left_reg - 1'b1;
            end
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pixel.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            error_reg     <= '0;
            major_reg     <= '0;
            minor_reg     <= '0;
            left_reg      <= '0;
            x_neg_reg     <= 1'b0;
            y_neg_reg     <= 1'b0;
            swapped_reg   <= 1'b0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            error_reg     <= error_next;
            major_reg     <= major_next;
            minor_reg     <= minor_next;
            left_reg      <= left_next;
            x_neg_reg     <= x_neg_next;
            y_neg_reg     <= y_neg_next;
            swapped_reg   <= swapped_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_x_reg    <= cur_x_reg;
            out_y_reg    <= cur_y_reg;
            out_last_reg <= is_last;
        end
    end

endmodule : ilr_back
`default_nettype wire

// ----- hdl/integer_line_rasterizer.sv -----
// Top level of the integer Bresenham line rasterizer.
//
// Usage: send command words on cmd. A word with kind = load carries two
// signed endpoints and starts a new line, replacing any line in progress;
// it produces no pixel. Each word with kind = step produces one pixel word
// on the pixel channel while a line is active, with last set on the final
// pixel. A line of major length L yields L + 1 pixels; a zero-length line
// yields its start point once. Step words with no active line are dropped.
// Throughput: one command word per cycle and one pixel per cycle while
// the pixel receiver does not stall. The front end computes deltas and
// octant in the accept cycle, a two-entry queue holds the classified
// word, and the back end performs one Bresenham step per cycle into the
// output register; a step word passes a queue entry and then the output
// register before its pixel word turns valid. When the pixel receiver
// stalls, the back end holds its state and the queue fills; cmd.ready
// drops only once it is full. Reset (rst_n low, asynchronous) empties
// the queue, clears the output valid flag and leaves no line loaded.
`default_nettype none
module integer_line_rasterizer (
    input  wire logic    clk,
    input  wire logic    rst_n,
    ilr_cmd_if.sink      cmd,
    ilr_pixel_if.source  pixel
);

    ilr_pkg::queue_wr_t queue_wr;
    ilr_pkg::queue_rd_t queue_rd;
    logic               queue_full;
    logic               queue_pop;

    // Classify incoming words; loads get their deltas and step signs here.
    ilr_front u_front (
        .cmd        (cmd),
        .queue_full (queue_full),
        .queue_wr   (queue_wr)
    );

    // Decouple the accept side from the stepping side.
    ilr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .queue_wr   (queue_wr),
        .pop        (queue_pop),
        .full       (queue_full),
        .queue_rd   (queue_rd)
    );

    // Hold the line state and advance one pixel per step word.
    ilr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .queue_rd   (queue_rd),
        .pop        (queue_pop),
        .pixel      (pixel)
    );

endmodule : integer_line_rasterizer
`default_nettype wire

// ----- tb/integer_line_rasterizer_checker.sv -----
// Watcher that predicts each pixel word of the line rasterizer and compares it.
module integer_line_rasterizer_checker
    import ilr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ilr_cmd_if   cmd,
    ilr_pixel_if pixel,
    output int   error_count,
    output int   pixels_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        coord_t x;
        coord_t y;
        logic   last;
    } pixel_word_t;

    pixel_word_t expected_pixels[$];
    int          mismatches;

    // Line state, kept the way the Bresenham walk needs it.
    coord_t line_x;
    coord_t line_y;
    int     decision;
    int     major_len;
    int     minor_len;
    int     pixels_to_go;
    logic   x_back;
    logic   y_back;
    logic   y_major;
    logic   line_live;

    assign error_count = mismatches;

    // Apply one accepted command word to the line state; queue its pixel, if any.
    task automatic rasterize_word(input logic kind, input coord_t sx_w, input coord_t sy_w,
                                  input coord_t ex_w, input coord_t ey_w);
        int          sx;
        int          sy;
        int          ex;
        int          ey;
        int          dx;
        int          dy;
        pixel_word_t px;
        sx = int'(sx_w);
        sy = int'(sy_w);
        ex = int'(ex_w);
        ey = int'(ey_w);
        if (kind == KIND_LOAD)
        begin
            dx = (ex > sx) ? ex - sx : sx - ex;
            dy = (ey > sy) ? ey - sy : sy - ey;
            line_x       = sx_w;
            line_y       = sy_w;
            x_back       = !(sx < ex);
            y_back       = !(sy < ey);
            y_major      = dx < dy;
            major_len    = y_major ? dy : dx;
            minor_len    = y_major ? dx : dy;
            decision     = 2 * minor_len - major_len;
            pixels_to_go = major_len + 1;
            line_live    = 1'b1;
        end
        else if (line_live)
        begin
            px.x    = line_x;
            px.y    = line_y;
            px.last = (pixels_to_go <= 1);
            expected_pixels.insert(expected_pixels.size(), px);
            if (px.last)
            begin
                pixels_to_go = 0;
                line_live    = 1'b0;
            end
            else
            begin
                if (decision >= 0)
                begin
                    if (y_major)
                        line_x = coord_t'(int'(line_x) + (x_back ? -1 : 1));
                    else
                        line_y = coord_t'(int'(line_y) + (y_back ? -1 : 1));
                    decision -= 2 * major_len;
                end
                if (y_major)
                    line_y = coord_t'(int'(line_y) + (y_back ? -1 : 1));
                else
                    line_x = coord_t'(int'(line_x) + (x_back ? -1 : 1));
                decision += 2 * minor_len;
                pixels_to_go -= 1;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_x       = '0;
            line_y       = '0;
            decision     = 0;
            major_len    = 0;
            minor_len    = 0;
            pixels_to_go = 0;
            x_back       = 1'b0;
            y_back       = 1'b0;
            y_major      = 1'b0;
            line_live    = 1'b0;
            mismatches   = 0;
            expected_pixels.delete();
            pixels_pending <= 0;
        end
        else
        begin
            if (pixel.valid && pixel.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: unexpected pixel word x=%0d y=%0d last=%0b", $time,
                             pixel.pixel_x, pixel.pixel_y, pixel.last);
                    mismatches++;
                end
                else
                begin
                    if (pixel.pixel_x !== expected_pixels[0].x)
                    begin
                        $display("%0t: pixel_x expected %0d, got %0d", $time,
                                 expected_pixels[0].x, pixel.pixel_x);
                        mismatches++;
                    end
                    if (pixel.pixel_y !== expected_pixels[0].y)
                    begin
                        $display("%0t: pixel_y expected %0d, got %0d", $time,
                                 expected_pixels[0].y, pixel.pixel_y);
                        mismatches++;
                    end
                    if (pixel.last !== expected_pixels[0].last)
                    begin
                        $display("%0t: last expected %0b, got %0b", $time,
                                 expected_pixels[0].last, pixel.last);
                        mismatches++;
                    end
                    void'(expected_pixels.pop_front());
                end
            end
            if (cmd.valid && cmd.ready)
                rasterize_word(cmd.kind, cmd.start_x, cmd.start_y, cmd.end_x, cmd.end_y);
            pixels_pending <= expected_pixels.size();
        end
    end

endmodule : integer_line_rasterizer_checker

// ----- tb/integer_line_rasterizer_tb.sv -----
// Top of the line rasterizer testbench: clock, reset, command stimulus and verdict.
module integer_line_rasterizer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ilr_pkg::*;

    // Far above the slowest correct run: ~600 words, each with random sender and
    // receiver gaps, plus one long receiver hold-off of HOLD_CYCLES.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int WORK_TARGET  = 500;
    localparam int QUIET_AFTER  = 430;
    localparam int HOLD_CYCLES  = 300;
    localparam int COORD_MIN    = -(1 << (COORD_BITS - 1));
    localparam int COORD_MAX    = (1 << (COORD_BITS - 1)) - 1;

    logic clk;
    logic rst_n;
    int   error_count;
    int   pixels_pending;
    bit   quiet;
    bit   hold_req;
    int   work_items;

    ilr_cmd_if   cmd();
    ilr_pixel_if pixel();

    integer_line_rasterizer u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .pixel (pixel)
    );

    integer_line_rasterizer_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .pixel          (pixel),
        .error_count    (error_count),
        .pixels_pending (pixels_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Give up once the cycle budget is spent.
    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Pixel receiver: random stall bursts, plus one long hold-off on request.
    // The hold-off is counted here so the sender keeps offering words meanwhile.
    initial
    begin
        int hold_left;
        int gap_left;
        hold_left = 0;
        gap_left  = 0;
        pixel.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                pixel.ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                pixel.ready <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                pixel.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                gap_left = $urandom_range(0, 4);
                pixel.ready <= 1'b0;
            end
            else
                pixel.ready <= 1'b1;
        end
    end

    // Offer one command word and hold it until it is accepted. Valid stays
    // high on return so back-to-back words need no extra edge.
    task automatic send_word(input kind_t kind, input int sx, input int sy,
                             input int ex, input int ey);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            cmd.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        cmd.valid   <= 1'b1;
        cmd.kind    <= kind;
        cmd.start_x <= coord_t'(sx);
        cmd.start_y <= coord_t'(sy);
        cmd.end_x   <= coord_t'(ex);
        cmd.end_y   <= coord_t'(ey);
        do
            @(posedge clk);
        while (!cmd.ready);
    endtask

    // Step words ignore their coordinates; fill them with noise.
    task automatic send_steps(input int count);
        repeat (count)
            send_word(KIND_STEP, $urandom_range(0, 4095), $urandom_range(0, 4095),
                      $urandom_range(0, 4095), $urandom_range(0, 4095));
    endtask

    // Stop offering words and wait until every predicted pixel has arrived.
    // The extra edge lets the checker count the last accepted word.
    task automatic drain_pixels();
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (pixels_pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int  sx;
        int  sy;
        int  ex;
        int  ey;
        int  dx;
        int  dy;
        int  span;
        int  steps;
        int  pick;
        bit  pressed;

        quiet      = 1'b0;
        hold_req   = 1'b0;
        pressed    = 1'b0;
        work_items = 0;
        rst_n       = 1'b0;
        cmd.valid   <= 1'b0;
        cmd.kind    <= KIND_STEP;
        cmd.start_x <= '0;
        cmd.start_y <= '0;
        cmd.end_x   <= '0;
        cmd.end_y   <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        // Step before any line is loaded: drop it.
        send_steps(1);
        // Zero-length line at the coordinate extremes: one pixel, then drop.
        send_word(KIND_LOAD, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
        send_steps(2);
        // Equal deltas walking toward smaller x and y: x stays the major axis.
        send_word(KIND_LOAD, 0, 0, -2, -2);
        send_steps(3);
        // Steep line with negative x step: axes swap.
        send_word(KIND_LOAD, 1, 1, 0, 3);
        send_steps(3);
        // Zero delta on x: x never moves.
        send_word(KIND_LOAD, 5, 0, 5, 2);
        send_steps(3);
        // Full-span diagonal, cut short by a new load that replaces it.
        send_word(KIND_LOAD, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        send_steps(2);
        send_word(KIND_LOAD, 0, 0, 1, 0);
        send_steps(3);
        work_items = 17;

        // Random part: mostly whole lines with random content, some cut short,
        // some overrun into dropped steps, and some pure noise.
        while (work_items < WORK_TARGET)
        begin
            if (work_items >= QUIET_AFTER)
                quiet = 1'b1;

            // Fill the block once: long line, long receiver hold-off, then a
            // sender pause until every pixel is out.
            if (!pressed && work_items >= 250)
            begin
                pressed = 1'b1;
                send_word(KIND_LOAD, COORD_MIN, 0, COORD_MAX, 3);
                hold_req = 1'b1;
                send_steps(40);
                drain_pixels();
                work_items += 41;
            end

            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                // Noise word: any kind, any fields.
                sx = $urandom_range(0, 4095);
                sy = $urandom_range(0, 4095);
                ex = $urandom_range(0, 4095);
                ey = $urandom_range(0, 4095);
                if ($urandom_range(0, 1))
                begin
                    send_word(KIND_LOAD, sx, sy, ex, ey);
                    work_items++;
                end
                else
                    send_word(KIND_STEP, sx, sy, ex, ey);
            end
            else
            begin
                sx = int'(coord_t'($urandom_range(0, 4095)));
                sy = int'(coord_t'($urandom_range(0, 4095)));
                if ($urandom_range(0, 7) == 0)
                begin
                    // Endpoints anywhere: long lines, only partly walked.
                    ex = int'(coord_t'($urandom_range(0, 4095)));
                    ey = int'(coord_t'($urandom_range(0, 4095)));
                end
                else
                begin
                    // Short line in a random octant; flip a delta that leaves range.
                    dx = $urandom_range(0, 12);
                    dy = $urandom_range(0, 12);
                    ex = $urandom_range(0, 1) ? sx + dx : sx - dx;
                    ey = $urandom_range(0, 1) ? sy + dy : sy - dy;
                    if (ex > COORD_MAX || ex < COORD_MIN)
                        ex = 2 * sx - ex;
                    if (ey > COORD_MAX || ey < COORD_MIN)
                        ey = 2 * sy - ey;
                end
                dx = (ex > sx) ? ex - sx : sx - ex;
                dy = (ey > sy) ? ey - sy : sy - ey;
                span = ((dx > dy) ? dx : dy) + 1;
                if (pick == 1)
                    steps = $urandom_range(0, span);
                else if (pick == 2)
                    steps = span + $urandom_range(1, 3);
                else
                    steps = span;
                if (steps > 40)
                    steps = $urandom_range(1, 40);
                send_word(KIND_LOAD, sx, sy, ex, ey);
                send_steps(steps);
                work_items += 1 + ((steps < span) ? steps : span);
            end
        end

        // Drain, then let the pipeline settle before the verdict.
        drain_pixels();
        repeat (8) @(posedge clk);
        if (error_count == 0 && pixels_pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule : integer_line_rasterizer_tb

// ----- integer_line_rasterizer.f -----
hdl/ilr_pkg.sv
hdl/ilr_if.sv
hdl/ilr_front.sv
hdl/ilr_queue.sv
hdl/ilr_back.sv
hdl/integer_line_rasterizer.sv
tb/integer_line_rasterizer_checker.sv
tb/integer_line_rasterizer_tb.sv
